@@ hw/rtl/dq_pkg.sv @@
// dq_pkg: command and status codes and fixed field widths of the double-ended queue
// no dependencies
package dq_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_W    = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

@@ hw/rtl/double_ended_queue.sv @@
// double_ended_queue: bounded deque in a ring ram, front index and entry count in flops
// depends on dq_pkg and dq_ram
// output path: push, error and unused commands go straight into the output register on transfer;
// pop and peek go through the registered read of the ring ram, then into the output register
// throughput: one push per cycle while the output is taken; a pop or peek blocks input while its read is pending
// reset: front index, entry count and output valid cleared; ram contents undefined, no sweep
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [CMD_W-1:0]           cmd_i,
  input  logic signed [OUT_W-1:0]    push_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OUT_W-1:0]    out_value_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic                       now_empty_o,
  output logic                       now_full_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

  logic [AW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic                rd_pend_q, rd_pend_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_value_q, out_value_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                now_empty_q, now_empty_d;
  logic                now_full_q, now_full_d;

  logic                  in_xfer;
  logic                  is_empty, is_full;
  logic [AW:0]           tail_sum, back_sum;
  logic [AW-1:0]         tail_ix, back_ix, front_dec, front_inc;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
    logic [AW:0] red;
    red = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
    return red[AW-1:0];
  endfunction

  assign in_ready_o = !rd_pend_q && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == DEPTH_C);

  assign tail_sum  = {1'b0, front_q} + (AW + 1)'(count_q);
  assign back_sum  = tail_sum - (AW + 1)'(1);
  assign tail_ix   = wrap(tail_sum);
  assign back_ix   = wrap(back_sum);
  assign front_dec = (front_q == '0) ? LAST_IX : (front_q - AW'(1));
  assign front_inc = (front_q == LAST_IX) ? '0 : (front_q + AW'(1));
  assign ram_wdata = DATA_WIDTH'($unsigned(push_value_i));

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    rd_pend_d   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = front_q;
    if (rd_pend_q) begin
      out_value_d = OUT_W'($signed(ram_rdata));
      out_valid_d = 1'b1;
    end
    if (in_xfer) begin
      out_value_d = '0;
      status_d    = ST_OK;
      out_valid_d = 1'b1;
      case (cmd_i)
        CMD_PUSH_FRONT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            front_d  = front_dec;
            ram_addr = front_dec;
            ram_we   = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            ram_addr = tail_ix;
            ram_we   = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        CMD_POP_FRONT, CMD_PEEK_FRONT: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            ram_addr    = front_q;
            ram_re      = 1'b1;
            rd_pend_d   = 1'b1;
            out_valid_d = 1'b0;
            if (cmd_i == CMD_POP_FRONT) begin
              front_d = front_inc;
              count_d = count_q - CW'(1);
            end
          end
        end
        CMD_POP_BACK, CMD_PEEK_BACK: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            ram_addr    = back_ix;
            ram_re      = 1'b1;
            rd_pend_d   = 1'b1;
            out_valid_d = 1'b0;
            if (cmd_i == CMD_POP_BACK) begin
              count_d = count_q - CW'(1);
            end
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    now_empty_d = now_empty_q;
    now_full_d  = now_full_q;
    if (in_xfer) begin
      now_empty_d = (count_d == '0);
      now_full_d  = (count_d == DEPTH_C);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    status_q    <= status_d;
    now_empty_q <= now_empty_d;
    now_full_q  <= now_full_d;
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign now_empty_o = now_empty_q;
  assign now_full_o  = now_full_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count beyond depth");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LAST_IX)
    else $error("front index out of range");

  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> out_valid_q)
    else $error("read data not captured");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_full && (cmd_i == CMD_PUSH_FRONT || cmd_i == CMD_PUSH_BACK))
    |=> ($stable(count_q) && $stable(front_q)))
    else $error("push on full changed state");

  a_pend_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !ram_we)
    else $error("write during pending read");

endmodule

@@ hw/rtl/dq_ram.sv @@
// dq_ram: generic single-port synchronous ram, registered read
// no dependencies
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
